// ===== design/fring_pkg.sv =====
// Shared types, constants and helper functions for the display frame ring.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fring_pkg;

    // Ring geometry
    localparam int SLOTS    = 8;
    localparam int HANDLE_W = 32;
    localparam int CUR_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);

    // Port field widths
    localparam int CFG_W       = 4;
    localparam int IN_HANDLE_W = 32;
    localparam int TS_W        = 64;
    localparam int IVL_W       = 9;

    // Action codes
    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Reset value of the slot count register
    localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = CFG_W'(8);

    // Display interval arithmetic
    localparam int US_PER_MS = 1000;
    localparam int IVL_BIAS  = 10;
    localparam int IVL_MIN   = 5;
    localparam int IVL_MAX   = 500;
    localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(40);

    // Divide by 1000 as multiply by ceil(2^38 / 1000), exact for 32-bit operands
    localparam int DIV_SHIFT = 38;
    localparam int MAG_W     = 31;
    localparam int MAGIC_W   = 29;
    localparam int PROD_W    = MAG_W + MAGIC_W;
    localparam int QUOT_W    = PROD_W - DIV_SHIFT;
    localparam longint DIV_MAGIC_L =
        ((longint'(1) <<< DIV_SHIFT) + longint'(US_PER_MS) - 1) / longint'(US_PER_MS);
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = MAGIC_W'(DIV_MAGIC_L);

    typedef logic [CUR_W-1:0] cursor_t;
    typedef logic [CNT_W-1:0] count_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TS_W-1:0]     stamp;
    } slot_t;

    // Control from the sequencer to the interval unit
    typedef struct packed {
        logic start;   // a transaction is accepted this cycle
        logic store;   // the accepted transaction is a store
        logic commit;  // the result is written out this cycle
    } ivl_ctrl_t;

    // Slots in use: zero acts as one, large values saturate to SLOTS
    function automatic count_t slots_in_use(logic [CFG_W-1:0] cnt);
        count_t res;
        if (cnt == '0) begin
            res = CNT_W'(1);
        end else if (int'(cnt) > SLOTS) begin
            res = CNT_W'(SLOTS);
        end else begin
            res = CNT_W'(cnt);
        end
        return res;
    endfunction

    // Cursor beyond the built ring reads as slot zero
    function automatic cursor_t clamp_cursor(cursor_t cur);
        cursor_t res;
        if (int'(cur) >= SLOTS) begin
            res = '0;
        end else begin
            res = cur;
        end
        return res;
    endfunction

    // Successor of a cursor, wrapping at the slots in use
    function automatic cursor_t next_pos(cursor_t cur, count_t n);
        logic [CUR_W:0] nx;
        cursor_t        res;
        nx = {1'b0, cur} + (CUR_W+1)'(1);
        if (nx >= (CUR_W+1)'(n)) begin
            res = '0;
        end else begin
            res = nx[CUR_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/frame_ring_overwrite_oldest.sv =====
// Display frame ring that overwrites the oldest frame when full.
// Flow: slot memory read and interval multiply in the work state, then write-back
// to the output register in the done state. The sequencer holds one transaction through
// to write-back, so a new transaction is accepted only after the last result is written out.
// Reset (aresetn, synchronous): filled flags, cursors, last timestamp cleared,
// interval 40 ms, slot count 8; slot memory contents are not cleared.
`timescale 1ns / 1ps

module frame_ring_overwrite_oldest (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [fring_pkg::IN_HANDLE_W-1:0] s_frame_handle,
    input  logic [fring_pkg::TS_W-1:0]        s_frame_timestamp,
    input  logic                              s_store_ok,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_accepted,
    output logic                              m_frame_valid,
    output logic [fring_pkg::IN_HANDLE_W-1:0] m_out_handle,
    output logic [fring_pkg::TS_W-1:0]        m_out_timestamp,
    output logic [fring_pkg::IVL_W-1:0]       m_display_interval,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fring_pkg::CFG_W-1:0]       cfg_data
);
    import fring_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WORK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;

    // Held transaction
    logic                act_reg;
    logic                ok_reg;
    logic [HANDLE_W-1:0] handle_item_reg;
    logic [TS_W-1:0]     stamp_reg;

    // Ring control state
    cursor_t             rd_cursor_reg;
    cursor_t             wr_cursor_reg;
    logic [SLOTS-1:0]    filled_reg;
    logic [CFG_W-1:0]    slot_count_reg;

    // Output register
    logic                m_valid_reg;
    logic                m_accepted_reg;
    logic                m_frame_valid_reg;
    logic [IN_HANDLE_W-1:0] m_out_handle_reg;
    logic [TS_W-1:0]     m_out_timestamp_reg;
    logic [IVL_W-1:0]    m_display_interval_reg;

    logic                s_accept;
    logic                fin;
    logic                is_store;
    logic                tick_hit;
    count_t              n_use;
    cursor_t             rc;
    cursor_t             wc;
    cursor_t             rc_succ;
    cursor_t             wc_succ;
    slot_t               wr_data;
    slot_t               rd_data;
    ivl_ctrl_t           ivl_ctrl;
    logic [IVL_W-1:0]    ivl_now;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;
    assign fin       = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Cursor arithmetic
    always_comb begin
        n_use    = slots_in_use(slot_count_reg);
        rc       = clamp_cursor(rd_cursor_reg);
        wc       = clamp_cursor(wr_cursor_reg);
        rc_succ  = next_pos(rc, n_use);
        wc_succ  = next_pos(wc, n_use);
        is_store = (act_reg == ACT_STORE);
        tick_hit = !is_store && filled_reg[rc];
        wr_data  = '{handle: handle_item_reg, stamp: stamp_reg};
    end

    fring_slot_mem u_slot_mem (
        .aclk    (aclk),
        .wr_en   (fin && is_store),
        .wr_addr (wc),
        .wr_data (wr_data),
        .rd_en   (state_reg == ST_WORK),
        .rd_addr (rc),
        .rd_data (rd_data)
    );

    assign ivl_ctrl = '{start: s_accept, store: (s_action == ACT_STORE), commit: fin};

    fring_interval u_interval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ivl_ctrl),
        .stamp    (s_frame_timestamp),
        .interval (ivl_now)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (fin) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Transaction capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg         <= s_action;
            ok_reg          <= s_store_ok;
            handle_item_reg <= HANDLE_W'(s_frame_handle);
            stamp_reg       <= s_frame_timestamp;
        end
    end

    // Ring state, configuration and sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rd_cursor_reg  <= '0;
            wr_cursor_reg  <= '0;
            filled_reg     <= '0;
            slot_count_reg <= SLOT_COUNT_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                slot_count_reg <= cfg_data;
            end
            if (fin) begin
                if (is_store) begin
                    // full ring: skip the read cursor past the oldest frame
                    if ((rc == wc) && filled_reg[rc_succ]) begin
                        rd_cursor_reg <= rc_succ;
                    end
                    filled_reg[wc] <= ok_reg;
                    if (ok_reg) begin
                        wr_cursor_reg <= wc_succ;
                    end
                end else if (tick_hit) begin
                    filled_reg[rc] <= 1'b0;
                    rd_cursor_reg  <= rc_succ;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin) begin
            m_accepted_reg         <= is_store && ok_reg;
            m_frame_valid_reg      <= tick_hit;
            m_out_handle_reg       <= tick_hit ? IN_HANDLE_W'(rd_data.handle) : '0;
            m_out_timestamp_reg    <= tick_hit ? rd_data.stamp : '0;
            m_display_interval_reg <= ivl_now;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_accepted         = m_accepted_reg;
    assign m_frame_valid      = m_frame_valid_reg;
    assign m_out_handle       = m_out_handle_reg;
    assign m_out_timestamp    = m_out_timestamp_reg;
    assign m_display_interval = m_display_interval_reg;

`ifndef SYNTH
    // Reported interval always within the allowed range
    a_interval_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_display_interval >= IVL_W'(IVL_MIN))
                 && (m_display_interval <= IVL_W'(IVL_MAX)))
        else $error("display interval out of range");

    // A result is either a store or a pop, never both
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_accepted && m_frame_valid))
        else $error("store and pop flagged together");

    // Without a popped frame the frame fields read zero
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_valid) |-> (m_out_handle == '0) && (m_out_timestamp == '0))
        else $error("frame fields nonzero without a popped frame");

    // No new transaction taken while one is in the sequencer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_WORK) && !s_ready)
        else $error("transaction accepted while busy");
`endif

endmodule

// ===== design/fring_slot_mem.sv =====
// Slot store: handle and timestamp of every ring slot, one write and one read port.
// Depends on fring_pkg for the slot type and ring depth.
`timescale 1ns / 1ps

module fring_slot_mem (
    input  logic              aclk,
    input  logic              wr_en,
    input  fring_pkg::cursor_t wr_addr,
    input  fring_pkg::slot_t  wr_data,
    input  logic              rd_en,
    input  fring_pkg::cursor_t rd_addr,
    output fring_pkg::slot_t  rd_data
);
    import fring_pkg::*;

    slot_t mem [SLOTS];
    slot_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/fring_interval.sv =====
// Display interval unit: timestamp spacing, divide by 1000 via reciprocal, range check.
// Depends on fring_pkg for widths, constants and the control struct.
`timescale 1ns / 1ps

module fring_interval (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  fring_pkg::ivl_ctrl_t        ctrl,
    input  logic [fring_pkg::TS_W-1:0]  stamp,
    output logic [fring_pkg::IVL_W-1:0] interval
);
    import fring_pkg::*;

    logic [TS_W-1:0]   last_time_reg;
    logic [IVL_W-1:0]  interval_reg;
    logic [IVL_W-1:0]  interval_next;
    logic              cand_reg;
    logic              cand_next;
    logic [MAG_W-1:0]  mag_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [31:0]       diff;
    logic [QUOT_W-1:0] quot;
    logic              hit;

    // Low 32 bits of the spacing; a negative spacing can never land in range
    always_comb begin
        diff      = stamp[31:0] - last_time_reg[31:0];
        cand_next = ctrl.store && (last_time_reg != '0) && !diff[31];
    end

    // Capture on acceptance, multiply in the following cycle
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            mag_reg <= diff[MAG_W-1:0];
        end
        prod_reg <= {{MAGIC_W{1'b0}}, mag_reg} * {{MAG_W{1'b0}}, DIV_MAGIC};
    end

    // Quotient and range check
    always_comb begin
        quot = prod_reg[PROD_W-1:DIV_SHIFT];
        hit  = cand_reg
            && (quot >= QUOT_W'(IVL_MIN + IVL_BIAS))
            && (quot <= QUOT_W'(IVL_MAX + IVL_BIAS));
        interval_next = hit ? IVL_W'(quot - QUOT_W'(IVL_BIAS)) : interval_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            interval_reg  <= IVL_RESET;
            cand_reg      <= 1'b0;
        end else begin
            if (ctrl.start) begin
                cand_reg <= cand_next;
                if (ctrl.store) begin
                    last_time_reg <= stamp;
                end
            end
            if (ctrl.commit) begin
                interval_reg <= interval_next;
            end
        end
    end

    assign interval = interval_next;

endmodule
